// ===== rtl/core/ble_pkg.sv =====
// Shared types and constants of the bounded line editor.
// No dependencies; imported by bounded_line_editor.
package ble_pkg;

   localparam int RESET_LINE_LIMIT = 16;
   localparam logic [2:0] GRID_LAST = 3'd5;

   typedef enum logic [1:0] {
      CMD_LOAD_BEGIN = 2'd0,
      CMD_LOAD_CHAR  = 2'd1,
      CMD_PAD        = 2'd2,
      CMD_READ       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_INSERT,
      ACT_BACKSPACE,
      ACT_DELETE,
      ACT_OVERWRITE,
      ACT_LEFT,
      ACT_RIGHT,
      ACT_FINISH
   } act_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT_UP,
      ST_DRAIN_UP,
      ST_PLACE,
      ST_SHIFT_DN,
      ST_DRAIN_DN,
      ST_RESP
   } state_type;

   localparam logic [7:0] PICKER_TABLE [0:5][0:5] = '{
      '{"E", "T", "A", "O", "I", "N"},
      '{"S", "R", "H", "L", "D", "C"},
      '{"U", "M", "W", "F", "G", "P"},
      '{"Y", "B", "V", "K", "X", "J"},
      '{"Q", "Z", "0", "1", "2", "3"},
      '{"4", "5", "6", "7", "8", "9"}
   };

   function automatic logic [7:0] picker_char(input logic [2:0] row, input logic [2:0] col);
      logic [7:0] ch;
      ch = 8'd0;
      if (row <= GRID_LAST && col <= GRID_LAST) begin
         ch = PICKER_TABLE[row][col];
      end
      return ch;
   endfunction

endpackage

// ===== rtl/core/ble_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ble_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bounded_line_editor.sv =====
// Bounded line editor: zero-terminated text line in a RAM with cursor and 6x6 picker.
// Load, begin-load and simple pad transactions go from idle straight to the response state;
// a read or cursor right adds a RAM read state, and insert, backspace and delete shift the
// line one byte a cycle through the text RAM port pair.
// One transaction at a time; the next is taken once the response is registered.
// Synchronous reset; per-entry valid bits empty the line at once. Uses ble_pkg, ble_ram.
module bounded_line_editor #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,    // line length limit
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,      // cmd
   // load_char[7:0], direction_mask[11:8], press_insert[12], press_backspace[13],
   // press_delete[14], press_overwrite[15], press_cursor_left[16],
   // press_cursor_right[17], press_finish[18], read_index[23:19]
   input  logic [23:0] req_tdata,
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cursor_pos[4:0], picker_col[7:5], picker_row[10:8], picked_char[18:11],
   // read_data[26:19], finished[27], zero[31:28]
   output logic [31:0] rsp_tdata
);

   import ble_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = $clog2(BUFFER_DEPTH + 1);
   localparam int CW = (LW > 6) ? LW : 6;
   localparam int RESET_LEN = (RESET_LINE_LIMIT > BUFFER_DEPTH) ? BUFFER_DEPTH
                                                                 : RESET_LINE_LIMIT;

   state_type state_ff, state_in;

   logic [AW-1:0]           cursor_ff, cursor_in;
   logic [AW-1:0]           lim_ff, lim_in;
   logic [2:0]              col_ff, col_in;
   logic [2:0]              row_ff, row_in;
   logic                    loading_ff, loading_in;
   logic [BUFFER_DEPTH-1:0] valid_ff, valid_in;
   logic [AW-1:0]           ptr_ff, ptr_in;
   logic [AW-1:0]           wa_ff, wa_in;
   logic                    pend_ff, pend_in;
   logic                    rvalid_ff;
   logic                    rd_right_ff, rd_right_in;
   logic [7:0]              rd_data_ff, rd_data_in;
   logic                    fin_ff, fin_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_data_ff, rsp_data_in;

   logic          mem_wen;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;
   logic [7:0]    rd_val;

   // request fields
   cmd_type    cmd;
   logic [7:0] load_char;
   logic [3:0] dir;
   logic [4:0] read_index;
   logic       fire;
   logic       rsp_free;

   logic [2:0]    col_nx, row_nx;
   logic [7:0]    picked_nx;
   act_type       act;
   logic          can_fwd;
   logic          at_start;
   logic          shift_needed;
   logic          idx_ok;
   logic [CW-1:0] csr_wide;
   logic [AW-1:0] lim_new;

   assign cmd        = cmd_type'(req_tuser);
   assign load_char  = req_tdata[7:0];
   assign dir        = req_tdata[11:8];
   assign read_index = req_tdata[23:19];

   assign req_tready = (state_ff == ST_IDLE);
   assign fire       = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rd_val       = rvalid_ff ? mem_rdata : 8'd0;
   assign can_fwd      = cursor_ff < lim_ff;
   assign at_start     = cursor_ff == '0;
   assign shift_needed = ({1'b0, cursor_ff} + (AW + 1)'(1)) < {1'b0, lim_ff};
   assign idx_ok       = 32'(read_index) < BUFFER_DEPTH;

   ble_ram #(
      .WIDTH(8),
      .DEPTH(BUFFER_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (mem_wen),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // picker move and action decode
   always_comb begin
      col_nx = col_ff;
      row_nx = row_ff;
      if (dir[0]) col_nx = (col_nx == 3'd0) ? GRID_LAST : col_nx - 3'd1;
      if (dir[1]) col_nx = (col_nx < GRID_LAST) ? col_nx + 3'd1 : 3'd0;
      if (dir[2]) row_nx = (row_nx == 3'd0) ? GRID_LAST : row_nx - 3'd1;
      if (dir[3]) row_nx = (row_nx < GRID_LAST) ? row_nx + 3'd1 : 3'd0;
      picked_nx = picker_char(row_nx, col_nx);

      priority if (req_tdata[12]) act = ACT_INSERT;
      else if (req_tdata[13])     act = ACT_BACKSPACE;
      else if (req_tdata[14])     act = ACT_DELETE;
      else if (req_tdata[15])     act = ACT_OVERWRITE;
      else if (req_tdata[16])     act = ACT_LEFT;
      else if (req_tdata[17])     act = ACT_RIGHT;
      else if (req_tdata[18])     act = ACT_FINISH;
      else                        act = ACT_NONE;
   end

   // clamped line length, kept as its last index
   always_comb begin
      csr_wide = CW'(csr_wr_data);
      if (csr_wide < CW'(2)) begin
         lim_new = AW'(1);
      end else if (csr_wide > CW'(BUFFER_DEPTH)) begin
         lim_new = AW'(BUFFER_DEPTH - 1);
      end else begin
         lim_new = AW'(csr_wide - CW'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               state_in = ST_RESP;
               unique case (cmd)
                  CMD_LOAD_BEGIN, CMD_LOAD_CHAR: state_in = ST_RESP;
                  CMD_READ: if (idx_ok) state_in = ST_READ;
                  CMD_PAD: begin
                     unique case (act)
                        ACT_INSERT:    if (can_fwd && shift_needed) state_in = ST_SHIFT_UP;
                        ACT_BACKSPACE: if (!at_start) state_in = ST_SHIFT_DN;
                        ACT_DELETE:    if (can_fwd) state_in = ST_SHIFT_DN;
                        ACT_RIGHT:     if (can_fwd) state_in = ST_READ;
                        default:       state_in = ST_RESP;
                     endcase
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_READ:     state_in = ST_RESP;
         ST_SHIFT_UP: if (ptr_ff == cursor_ff) state_in = ST_DRAIN_UP;
         ST_DRAIN_UP: state_in = ST_PLACE;
         ST_PLACE:    state_in = ST_RESP;
         ST_SHIFT_DN: if (ptr_ff == lim_ff) state_in = ST_DRAIN_DN;
         ST_DRAIN_DN: state_in = ST_RESP;
         ST_RESP:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      cursor_in    = cursor_ff;
      lim_in       = lim_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      loading_in   = loading_ff;
      valid_in     = valid_ff;
      ptr_in       = ptr_ff;
      wa_in        = wa_ff;
      pend_in      = 1'b0;
      rd_right_in  = rd_right_ff;
      rd_data_in   = rd_data_ff;
      fin_in       = fin_ff;
      mem_wen      = 1'b0;
      mem_waddr    = wa_ff;
      mem_wdata    = rd_val;
      mem_raddr    = ptr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_tready) rsp_valid_in = 1'b0;

      // write back of the byte read in the previous sweep cycle
      if (pend_ff) begin
         mem_wen         = 1'b1;
         valid_in[wa_ff] = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               rd_data_in = 8'd0;
               fin_in     = 1'b0;
               unique case (cmd)
                  CMD_LOAD_BEGIN: begin
                     valid_in   = '0;
                     cursor_in  = '0;
                     loading_in = 1'b1;
                  end
                  CMD_LOAD_CHAR: begin
                     if (loading_ff) begin
                        if (load_char == 8'd0) begin
                           loading_in = 1'b0;
                        end else if (can_fwd) begin
                           mem_wen             = 1'b1;
                           mem_waddr           = cursor_ff;
                           mem_wdata           = load_char;
                           valid_in[cursor_ff] = 1'b1;
                           cursor_in           = cursor_ff + AW'(1);
                        end
                     end
                  end
                  CMD_PAD: begin
                     loading_in = 1'b0;
                     col_in     = col_nx;
                     row_in     = row_nx;
                     unique case (act)
                        ACT_INSERT: begin
                           if (can_fwd) begin
                              valid_in[lim_ff] = 1'b0;
                              if (shift_needed) begin
                                 ptr_in = lim_ff - AW'(2);
                              end else begin
                                 mem_wen             = 1'b1;
                                 mem_waddr           = cursor_ff;
                                 mem_wdata           = picked_nx;
                                 valid_in[cursor_ff] = 1'b1;
                                 cursor_in           = cursor_ff + AW'(1);
                              end
                           end
                        end
                        ACT_BACKSPACE: begin
                           if (!at_start) begin
                              cursor_in = cursor_ff - AW'(1);
                              ptr_in    = cursor_ff;
                           end
                        end
                        ACT_DELETE: begin
                           if (can_fwd) ptr_in = cursor_ff + AW'(1);
                        end
                        ACT_OVERWRITE: begin
                           if (can_fwd) begin
                              mem_wen             = 1'b1;
                              mem_waddr           = cursor_ff;
                              mem_wdata           = picked_nx;
                              valid_in[cursor_ff] = 1'b1;
                              cursor_in           = cursor_ff + AW'(1);
                           end
                        end
                        ACT_LEFT: begin
                           if (!at_start) cursor_in = cursor_ff - AW'(1);
                        end
                        ACT_RIGHT: begin
                           mem_raddr   = cursor_ff;
                           rd_right_in = 1'b1;
                        end
                        ACT_FINISH: fin_in = 1'b1;
                        default: ;
                     endcase
                  end
                  CMD_READ: begin
                     mem_raddr   = AW'(read_index);
                     rd_right_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (rd_right_ff) begin
               if (rd_val != 8'd0) cursor_in = cursor_ff + AW'(1);
            end else begin
               rd_data_in = rd_val;
            end
         end
         ST_SHIFT_UP: begin
            pend_in = 1'b1;
            wa_in   = ptr_ff + AW'(1);
            ptr_in  = ptr_ff - AW'(1);
         end
         ST_PLACE: begin
            mem_wen             = 1'b1;
            mem_waddr           = cursor_ff;
            mem_wdata           = picker_char(row_ff, col_ff);
            valid_in[cursor_ff] = 1'b1;
            cursor_in           = cursor_ff + AW'(1);
         end
         ST_SHIFT_DN: begin
            pend_in = 1'b1;
            wa_in   = ptr_ff - AW'(1);
            ptr_in  = ptr_ff + AW'(1);
         end
         ST_DRAIN_DN: valid_in[lim_ff] = 1'b0;
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, fin_ff, rd_data_ff, picker_char(row_ff, col_ff),
                               row_ff, col_ff, 5'(cursor_ff)};
            end
         end
         default: ;
      endcase

      // register write: cut the line and saturate the cursor
      if (csr_wr_en) begin
         lim_in = lim_new;
         for (int i = 0; i < BUFFER_DEPTH; i++) begin
            if (AW'(i) >= lim_new) valid_in[i] = 1'b0;
         end
         if (cursor_ff > lim_new) cursor_in = lim_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         lim_ff       <= AW'(RESET_LEN - 1);
         col_ff       <= 3'd0;
         row_ff       <= 3'd0;
         loading_ff   <= 1'b0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         lim_ff       <= lim_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         loading_ff   <= loading_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      wa_ff       <= wa_in;
      rvalid_ff   <= valid_ff[mem_raddr];
      rd_right_ff <= rd_right_in;
      rd_data_ff  <= rd_data_in;
      fin_ff      <= fin_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for bounded_line_editor: directed and random request streams.
// A transaction-level editor model predicts every response; depends on ble_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
   import ble_pkg::*;

   localparam int LINE_DEPTH   = 32;
   localparam int SETTLE       = 4;
   localparam int TAIL_CYCLES  = 40;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;

   localparam int KEY_INSERT    = 0;
   localparam int KEY_BACKSPACE = 1;
   localparam int KEY_DELETE    = 2;
   localparam int KEY_OVERWRITE = 3;
   localparam int KEY_LEFT      = 4;
   localparam int KEY_RIGHT     = 5;
   localparam int KEY_FINISH    = 6;
   localparam int KEY_COUNT     = 7;

   localparam logic [3:0] DIR_LEFT  = 4'b0001;
   localparam logic [3:0] DIR_RIGHT = 4'b0010;
   localparam logic [3:0] DIR_UP    = 4'b0100;
   localparam logic [3:0] DIR_DOWN  = 4'b1000;

   localparam logic [7:0] PICK_GRID [0:5][0:5] = '{
      '{"E", "T", "A", "O", "I", "N"},
      '{"S", "R", "H", "L", "D", "C"},
      '{"U", "M", "W", "F", "G", "P"},
      '{"Y", "B", "V", "K", "X", "J"},
      '{"Q", "Z", "0", "1", "2", "3"},
      '{"4", "5", "6", "7", "8", "9"}
   };

   typedef struct packed {
      logic [4:0] read_index;
      logic [6:0] keys;
      logic [3:0] dir;
      logic [7:0] load_char;
   } req_fields_type;

   typedef struct packed {
      logic [3:0] spare;
      logic       finished;
      logic [7:0] read_data;
      logic [7:0] picked_char;
      logic [2:0] picker_row;
      logic [2:0] picker_col;
      logic [4:0] cursor_pos;
   } rsp_fields_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [5:0]  csr_wr_data = 6'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser   = 2'd0;
   logic [23:0] req_tdata   = 24'd0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;

   // editor model state
   logic [7:0]  line_buf [0:LINE_DEPTH-1];
   int          line_cursor;
   int          pick_col;
   int          pick_row;
   bit          line_loading;
   logic [5:0]  line_max;

   rsp_fields_type expected_views [$];
   int          fail_count   = 0;
   int          req_count    = 0;
   int          sender_idle  = 0;
   int          rsp_stall    = 0;
   int          hold_left    = 0;
   int          quiet_cycles = 0;

   bounded_line_editor u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int line_len();
      int m;
      m = line_max;
      if (m < 2) m = 2;
      if (m > LINE_DEPTH) m = LINE_DEPTH;
      return m;
   endfunction

   function automatic rsp_fields_type predict_editor(input cmd_type c, input req_fields_type d);
      rsp_fields_type r;
      int m;
      int i;
      int shift_at;
      logic [7:0] sel;
      r = '0;
      m = line_len();
      shift_at = -1;
      case (c)
         CMD_LOAD_BEGIN: begin
            for (i = 0; i < LINE_DEPTH; i++) line_buf[i] = 8'd0;
            line_cursor = 0;
            line_loading = 1'b1;
         end
         CMD_LOAD_CHAR: begin
            if (line_loading) begin
               if (d.load_char == 8'd0) begin
                  line_loading = 1'b0;
               end else if (line_cursor < m - 1) begin
                  line_buf[line_cursor] = d.load_char;
                  line_cursor++;
               end
            end
         end
         CMD_PAD: begin
            line_loading = 1'b0;
            if (d.dir[0]) pick_col = (pick_col == 0) ? 5 : pick_col - 1;
            if (d.dir[1]) pick_col = (pick_col < 5) ? pick_col + 1 : 0;
            if (d.dir[2]) pick_row = (pick_row == 0) ? 5 : pick_row - 1;
            if (d.dir[3]) pick_row = (pick_row < 5) ? pick_row + 1 : 0;
            sel = PICK_GRID[pick_row][pick_col];
            if (d.keys[KEY_INSERT]) begin
               if (line_cursor < m - 1) begin
                  for (i = m - 1; i > line_cursor; i--) line_buf[i] = line_buf[i-1];
                  line_buf[m-1] = 8'd0;
                  line_buf[line_cursor] = sel;
                  line_cursor++;
               end
            end else if (d.keys[KEY_BACKSPACE]) begin
               if (line_cursor > 0) begin
                  line_cursor--;
                  shift_at = line_cursor;
               end
            end else if (d.keys[KEY_DELETE]) begin
               if (line_cursor < m - 1) shift_at = line_cursor;
            end else if (d.keys[KEY_OVERWRITE]) begin
               if (line_cursor < m - 1) begin
                  line_buf[line_cursor] = sel;
                  line_cursor++;
               end
            end else if (d.keys[KEY_LEFT]) begin
               if (line_cursor > 0) line_cursor--;
            end else if (d.keys[KEY_RIGHT]) begin
               if (line_cursor < m - 1 && line_buf[line_cursor] != 8'd0) line_cursor++;
            end else if (d.keys[KEY_FINISH]) begin
               r.finished = 1'b1;
            end
            if (shift_at >= 0) begin
               for (i = shift_at; i + 1 < m; i++) line_buf[i] = line_buf[i+1];
               line_buf[m-1] = 8'd0;
            end
         end
         default: r.read_data = line_buf[d.read_index];
      endcase
      r.cursor_pos  = line_cursor[4:0];
      r.picker_col  = pick_col[2:0];
      r.picker_row  = pick_row[2:0];
      r.picked_char = PICK_GRID[pick_row][pick_col];
      return r;
   endfunction

   function automatic req_fields_type load_req(input logic [7:0] ch);
      req_fields_type d;
      d = req_fields_type'(24'($urandom));
      d.load_char = ch;
      return d;
   endfunction

   function automatic req_fields_type pad_req(input logic [3:0] dir, input logic [6:0] keys);
      req_fields_type d;
      d = req_fields_type'(24'($urandom));
      d.dir = dir;
      d.keys = keys;
      return d;
   endfunction

   function automatic req_fields_type read_req(input logic [4:0] idx);
      req_fields_type d;
      d = req_fields_type'(24'($urandom));
      d.read_index = idx;
      return d;
   endfunction

   // valid is left high after acceptance; callers that pause go through drain_line
   task automatic send_item(input cmd_type c, input req_fields_type d);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      expected_views.push_back(predict_editor(c, d));
      req_count++;
   endtask

   task automatic drain_line();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_line_limit(input logic [5:0] value);
      int m;
      int i;
      drain_line();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      line_max = value;
      m = line_len();
      for (i = m - 1; i < LINE_DEPTH; i++) line_buf[i] = 8'd0;
      if (line_cursor > m - 1) line_cursor = m - 1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_line(input int n);
      int i;
      send_item(CMD_LOAD_BEGIN, load_req(8'd0));
      for (i = 0; i < n; i++) send_item(CMD_LOAD_CHAR, load_req(8'($urandom_range(1, 255))));
      send_item(CMD_LOAD_CHAR, load_req(8'd0));
   endtask

   task automatic test_reset_state();
      send_item(CMD_READ, read_req(5'd0));
      send_item(CMD_READ, read_req(5'd31));
      send_item(CMD_PAD, pad_req(4'd0, 7'd0));
   endtask

   task automatic test_load();
      send_item(CMD_LOAD_BEGIN, load_req(8'd0));
      send_item(CMD_LOAD_CHAR, load_req("A"));
      send_item(CMD_LOAD_CHAR, load_req(8'hFF));
      send_item(CMD_LOAD_CHAR, load_req(8'h80));
      send_item(CMD_LOAD_CHAR, load_req(8'h01));
      send_item(CMD_LOAD_CHAR, load_req(8'd0));
      // not loading any more: dropped
      send_item(CMD_LOAD_CHAR, load_req("Q"));
      send_item(CMD_READ, read_req(5'd1));
   endtask

   task automatic test_picker();
      send_item(CMD_PAD, pad_req(DIR_LEFT, 7'd0));
      send_item(CMD_PAD, pad_req(DIR_UP, 7'd0));
      send_item(CMD_PAD, pad_req(DIR_RIGHT, 7'd0));
      send_item(CMD_PAD, pad_req(DIR_DOWN, 7'd0));
      send_item(CMD_PAD, pad_req(4'hF, 7'd0));
   endtask

   task automatic test_actions();
      send_item(CMD_LOAD_BEGIN, load_req(8'd0));
      send_item(CMD_LOAD_CHAR, load_req("A"));
      send_item(CMD_LOAD_CHAR, load_req("B"));
      send_item(CMD_LOAD_CHAR, load_req(8'd0));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_INSERT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_LEFT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_BACKSPACE));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_DELETE));
      send_item(CMD_PAD, pad_req(DIR_DOWN, 7'd1 << KEY_OVERWRITE));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_RIGHT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_RIGHT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_FINISH));
      send_item(CMD_PAD, pad_req(4'd0, 7'h7F));
      send_item(CMD_READ, read_req(5'd0));
      send_item(CMD_LOAD_BEGIN, load_req(8'd0));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_BACKSPACE));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_LEFT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_RIGHT));
   endtask

   task automatic test_length_extremes();
      // below the floor: behaves as two bytes
      set_line_limit(6'd0);
      send_item(CMD_LOAD_BEGIN, load_req(8'd0));
      send_item(CMD_LOAD_CHAR, load_req("X"));
      send_item(CMD_LOAD_CHAR, load_req("Y"));
      send_item(CMD_LOAD_CHAR, load_req(8'd0));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_INSERT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_DELETE));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_OVERWRITE));
      send_item(CMD_READ, read_req(5'd0));
      set_line_limit(6'd1);
      // pad sample ends a load in progress
      send_item(CMD_LOAD_BEGIN, load_req(8'd0));
      send_item(CMD_LOAD_CHAR, load_req("K"));
      send_item(CMD_PAD, pad_req(4'd0, 7'd0));
      send_item(CMD_LOAD_CHAR, load_req("L"));
      set_line_limit(6'd63);
      load_line(35);
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_LEFT));
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_INSERT));
      send_item(CMD_READ, read_req(5'd31));
      set_line_limit(6'd16);
      load_line(10);
      // shorter length cuts the line and pulls the cursor in
      set_line_limit(6'd5);
      send_item(CMD_READ, read_req(5'd3));
      send_item(CMD_READ, read_req(5'd4));
      set_line_limit(6'd42);
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_INSERT));
      set_line_limit(6'd21);
      send_item(CMD_PAD, pad_req(4'd0, 7'd1 << KEY_BACKSPACE));
      set_line_limit(6'(RESET_LINE_LIMIT));
   endtask

   task automatic test_backpressure();
      int i;
      drain_line();
      sender_idle = 0;
      rsp_stall   = 0;
      load_line(8);
      hold_left = HOLD_CYCLES;
      for (i = 0; i < 30; i++) begin
         if (i % 3 == 0) send_item(CMD_READ, read_req(5'($urandom_range(0, 31))));
         else send_item(CMD_PAD, pad_req(4'($urandom), 7'd1 << (i % KEY_COUNT)));
      end
      drain_line();
   endtask

   task automatic edit_session();
      int n_edits;
      int k;
      int pick;
      req_fields_type d;
      if ($urandom_range(0, 9) < 8) begin
         send_item(CMD_LOAD_BEGIN, load_req(8'($urandom)));
         n_edits = $urandom_range(0, line_len() + 1);
         for (k = 0; k < n_edits; k++)
            send_item(CMD_LOAD_CHAR, load_req(8'($urandom_range(1, 255))));
         if ($urandom_range(0, 3) != 0) send_item(CMD_LOAD_CHAR, load_req(8'd0));
      end
      n_edits = $urandom_range(5, 30);
      for (k = 0; k < n_edits; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            d = pad_req(4'($urandom), 7'd0);
            if ($urandom_range(0, 7) != 0) d.keys = 7'd1 << $urandom_range(0, KEY_COUNT - 1);
            send_item(CMD_PAD, d);
         end else if (pick < 70) begin
            send_item(CMD_PAD, pad_req(4'($urandom), 7'($urandom)));
         end else if (pick < 85) begin
            send_item(CMD_READ, read_req(5'($urandom)));
         end else if (pick < 92) begin
            send_item(CMD_LOAD_CHAR, load_req(8'($urandom_range(0, 3) == 0 ? 0 : $urandom)));
         end else begin
            send_item(cmd_type'($urandom_range(0, 3)), req_fields_type'(24'($urandom)));
         end
      end
   endtask

   task automatic test_random();
      int phase;
      int sub;
      int target;
      logic [5:0] len;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle = 0;  rsp_stall = 0;  end
            1: begin sender_idle = 73; rsp_stall = 0;  end
            2: begin sender_idle = 0;  rsp_stall = 73; end
            default: begin sender_idle = 34; rsp_stall = 34; end
         endcase
         for (sub = 0; sub < 3; sub++) begin
            case ($urandom_range(0, 5))
               0: len = 6'd0;
               1: len = 6'd2;
               2: len = 6'd32;
               3: len = 6'd63;
               default: len = 6'($urandom_range(0, 63));
            endcase
            set_line_limit(len);
            target = req_count + 85;
            while (req_count < target) edit_session();
         end
         drain_line();
      end
   endtask

   // response side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall);
      end
   end

   always @(posedge clock) begin
      rsp_fields_type got;
      rsp_fields_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_views.size() == 0) begin
            $error("response transaction with nothing expected: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_views.pop_front();
            if (got.cursor_pos !== want.cursor_pos) begin
               $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, got.cursor_pos);
               fail_count++;
            end
            if (got.picker_col !== want.picker_col) begin
               $error("picker_col: expected %0d, actual %0d", want.picker_col, got.picker_col);
               fail_count++;
            end
            if (got.picker_row !== want.picker_row) begin
               $error("picker_row: expected %0d, actual %0d", want.picker_row, got.picker_row);
               fail_count++;
            end
            if (got.picked_char !== want.picked_char) begin
               $error("picked_char: expected %h, actual %h", want.picked_char, got.picked_char);
               fail_count++;
            end
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
               fail_count++;
            end
            if (got.finished !== want.finished) begin
               $error("finished: expected %0d, actual %0d", want.finished, got.finished);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no transaction for %0d cycles", QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < LINE_DEPTH; i++) line_buf[i] = 8'd0;
      line_cursor  = 0;
      pick_col     = 0;
      pick_row     = 0;
      line_loading = 1'b0;
      line_max     = 6'(RESET_LINE_LIMIT);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load();
      test_picker();
      test_actions();
      test_length_extremes();
      test_backpressure();
      test_random();

      drain_line();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
